### rtl/ste_pkg.sv
`timescale 1ns / 1ps

package ste_pkg;

  // Field widths
  localparam int unsigned TypeW  = 8;
  localparam int unsigned DueW   = 24;
  localparam int unsigned DurW   = 16;
  localparam int unsigned SetupW = 16;
  localparam int unsigned ClockW = 28;
  localparam int unsigned PenW   = 48;
  localparam int unsigned TardW  = 40;
  localparam int unsigned CountW = 11;
  // lateness z = completion - due, signed
  localparam int unsigned ZW     = ClockW + 1;
  // 100 * z for the largest z still fits in this signed width
  localparam int unsigned PenIncW = 36;

  localparam logic [ClockW-1:0] ClockMax = {ClockW{1'b1}};
  localparam logic [TardW-1:0]  TardMax  = {TardW{1'b1}};
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [PenW-1:0]   PenMax   = {1'b0, {(PenW-1){1'b1}}};
  localparam logic [PenW-1:0]   PenMin   = {1'b1, {(PenW-1){1'b0}}};

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_LARGE_SETUP = 1'b0,
    CFG_SMALL_SETUP = 1'b1
  } cfg_reg_e;

  // Input word
  typedef struct packed {
    logic [TypeW-1:0] job_type;
    logic [DueW-1:0]  due_time;
    logic [DurW-1:0]  duration;
    logic             last_of_machine;
    logic             last_of_schedule;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic signed [PenW-1:0] scaled_tardiness;
    logic [TardW-1:0]       true_tardiness;
    logic [CountW-1:0]      late_jobs;
    logic [CountW-1:0]      large_setups;
    logic [ClockW-1:0]      peak_makespan;
    logic [ClockW-1:0]      makespan_spread;
    logic                   schedule_done;
  } out_word_t;

  // After the machine clock stage
  typedef struct packed {
    logic [ClockW-1:0] finish;
    logic [DueW-1:0]   due_time;
    logic              end_machine;
    logic              end_sched;
    logic [CountW-1:0] setups;
  } clk_stage_t;

  // After the lateness / makespan stage
  typedef struct packed {
    logic signed [PenIncW-1:0] pen_inc;
    logic                      is_late;
    logic [ClockW-1:0]         late_by;
    logic                      end_sched;
    logic [CountW-1:0]         setups;
    logic [ClockW-1:0]         longest;
    logic [ClockW-1:0]         spread;
  } late_stage_t;

endpackage

### rtl/schedule_tardiness_evaluator_core.sv
`timescale 1ns / 1ps

// Schedule tardiness evaluator. Jobs stream in machine by machine, one word
// per job, and every accepted word yields one result word carrying the running
// totals after that job. A new word can be taken every cycle unless the full
// pipeline is stalled; a result passes the input register, machine clock stage,
// lateness stage and output register. The per-cycle rate is held by the machine
// clock recurrence (set-up add, duration add, saturation) in the second stage
// and by the 48-bit saturating penalty accumulator in the output stage. Stages
// advance independently, so gaps collapse and words keep entering while a
// result waits in the output register. A word with last_of_schedule set closes
// its machine and, once its result is formed, returns all totals to their
// reset values; the set-up times in the configuration registers are kept.

module schedule_tardiness_evaluator_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [0:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i,
  // job words in
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ste_pkg::in_word_t     in_word_i,
  // result words out
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ste_pkg::out_word_t    out_word_o
);

  // Configuration registers
  logic [ste_pkg::SetupW-1:0] large_setup_q, small_setup_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      large_setup_q <= '0;
      small_setup_q <= '0;
    end else if (cfg_we_i) begin
      case (ste_pkg::cfg_reg_e'(cfg_index_i))
        ste_pkg::CFG_LARGE_SETUP: large_setup_q <= cfg_data_i;
        ste_pkg::CFG_SMALL_SETUP: small_setup_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  logic v0_q, v1_q, v2_q, out_v_q;
  logic adv0, adv1, adv2, adv3;
  logic fire1, fire2, fire3, accept;

  assign adv3   = !out_v_q || !out_stall_i;
  assign adv2   = !v2_q || adv3;
  assign adv1   = !v1_q || adv2;
  assign adv0   = !v0_q || adv1;
  assign accept = in_valid_i && adv0;
  assign fire1  = v0_q && adv1;
  assign fire2  = v1_q && adv2;
  assign fire3  = v2_q && adv3;

  assign in_stall_o  = !adv0;
  assign out_valid_o = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (adv0) v0_q    <= in_valid_i;
      if (adv1) v1_q    <= v0_q;
      if (adv2) v2_q    <= v1_q;
      if (adv3) out_v_q <= v2_q;
    end
  end

  // Input register
  ste_pkg::in_word_t in_q;

  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_word_i;
  end

  // Stage 1: machine clock and set-up counting
  logic [ste_pkg::ClockW-1:0] mclk_q, mclk_d;
  logic [ste_pkg::TypeW-1:0]  prev_type_q, prev_type_d;
  logic                       at_start_q, at_start_d;
  logic [ste_pkg::CountW-1:0] setups_q, setups_d;
  ste_pkg::clk_stage_t        s1_q, s1_d;

  logic                       type_change, new_setup, end_m;
  logic [ste_pkg::ClockW:0]   base, t_sum;
  logic [ste_pkg::SetupW-1:0] setup_t;
  logic [ste_pkg::ClockW-1:0] t_sat;
  logic [ste_pkg::CountW-1:0] setups_inc;

  always_comb begin
    type_change = (in_q.job_type != prev_type_q);
    new_setup   = at_start_q || type_change;
    end_m       = in_q.last_of_machine || in_q.last_of_schedule;
    setup_t     = type_change ? large_setup_q : small_setup_q;
    base        = at_start_q ? '0
                : ({1'b0, mclk_q} + {{(ste_pkg::ClockW + 1 - ste_pkg::SetupW){1'b0}}, setup_t});
    t_sum       = base + {{(ste_pkg::ClockW + 1 - ste_pkg::DurW){1'b0}}, in_q.duration};
    t_sat       = t_sum[ste_pkg::ClockW] ? ste_pkg::ClockMax : t_sum[ste_pkg::ClockW-1:0];
    setups_inc  = (new_setup && setups_q != ste_pkg::CountMax) ? setups_q + 1'b1 : setups_q;

    s1_d.finish      = t_sat;
    s1_d.due_time    = in_q.due_time;
    s1_d.end_machine = end_m;
    s1_d.end_sched   = in_q.last_of_schedule;
    s1_d.setups      = setups_inc;

    // a closed machine starts afresh
    mclk_d      = end_m ? '0 : t_sat;
    prev_type_d = end_m ? '0 : in_q.job_type;
    at_start_d  = end_m;
    setups_d    = in_q.last_of_schedule ? '0 : setups_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mclk_q      <= '0;
      prev_type_q <= '0;
      at_start_q  <= 1'b1;
      setups_q    <= '0;
    end else if (fire1) begin
      mclk_q      <= mclk_d;
      prev_type_q <= prev_type_d;
      at_start_q  <= at_start_d;
      setups_q    <= setups_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire1) s1_q <= s1_d;
  end

  // Stage 2: lateness, penalty term and makespan extremes
  logic [ste_pkg::ClockW-1:0] longest_q, longest_d, shortest_q, shortest_d;
  ste_pkg::late_stage_t       s2_q, s2_d;

  logic signed [ste_pkg::ZW-1:0]      z;
  logic signed [ste_pkg::PenIncW-1:0] z_ext;
  logic [ste_pkg::ClockW-1:0]         long_n, short_n;

  always_comb begin
    z     = $signed({1'b0, s1_q.finish})
          - $signed({{(ste_pkg::ZW - ste_pkg::DueW){1'b0}}, s1_q.due_time});
    z_ext = {{(ste_pkg::PenIncW - ste_pkg::ZW){z[ste_pkg::ZW-1]}}, z};

    // 100*z as 64z + 32z + 4z for on-time-or-late, plain z when early
    s2_d.pen_inc = z[ste_pkg::ZW-1] ? z_ext
                 : ((z_ext <<< 6) + (z_ext <<< 5) + (z_ext <<< 2));
    s2_d.is_late = !z[ste_pkg::ZW-1] && (z != '0);
    s2_d.late_by = z[ste_pkg::ClockW-1:0];

    long_n  = (s1_q.end_machine && s1_q.finish > longest_q) ? s1_q.finish : longest_q;
    short_n = (s1_q.end_machine && s1_q.finish < shortest_q) ? s1_q.finish : shortest_q;

    s2_d.end_sched = s1_q.end_sched;
    s2_d.setups    = s1_q.setups;
    s2_d.longest   = long_n;
    s2_d.spread    = (short_n <= long_n) ? long_n - short_n : '0;

    longest_d  = s1_q.end_sched ? '0 : long_n;
    shortest_d = s1_q.end_sched ? ste_pkg::ClockMax : short_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      longest_q  <= '0;
      shortest_q <= ste_pkg::ClockMax;
    end else if (fire2) begin
      longest_q  <= longest_d;
      shortest_q <= shortest_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire2) s2_q <= s2_d;
  end

  // Stage 3: saturating accumulators and output register
  logic signed [ste_pkg::PenW-1:0] pen_sum_q, pen_sum_d;
  logic [ste_pkg::TardW-1:0]       tard_q, tard_d;
  logic [ste_pkg::CountW-1:0]      late_q, late_d;
  ste_pkg::out_word_t              out_q, out_d;

  logic [ste_pkg::PenW:0]   pen_wide;
  logic [ste_pkg::PenW-1:0] pen_sat;
  logic [ste_pkg::TardW:0]  tard_wide;
  logic [ste_pkg::TardW-1:0] tard_sat;
  logic [ste_pkg::CountW-1:0] late_inc;

  always_comb begin
    pen_wide = {pen_sum_q[ste_pkg::PenW-1], pen_sum_q}
             + {{(ste_pkg::PenW + 1 - ste_pkg::PenIncW){s2_q.pen_inc[ste_pkg::PenIncW-1]}},
                s2_q.pen_inc};
    // overflow when the two top bits differ
    if (pen_wide[ste_pkg::PenW] != pen_wide[ste_pkg::PenW-1]) begin
      pen_sat = pen_wide[ste_pkg::PenW] ? ste_pkg::PenMin : ste_pkg::PenMax;
    end else begin
      pen_sat = pen_wide[ste_pkg::PenW-1:0];
    end

    tard_wide = {1'b0, tard_q}
              + (s2_q.is_late ? {{(ste_pkg::TardW + 1 - ste_pkg::ClockW){1'b0}}, s2_q.late_by}
                              : '0);
    tard_sat  = tard_wide[ste_pkg::TardW] ? ste_pkg::TardMax : tard_wide[ste_pkg::TardW-1:0];
    late_inc  = (s2_q.is_late && late_q != ste_pkg::CountMax) ? late_q + 1'b1 : late_q;

    out_d.scaled_tardiness = pen_sat;
    out_d.true_tardiness   = tard_sat;
    out_d.late_jobs        = late_inc;
    out_d.large_setups     = s2_q.setups;
    out_d.peak_makespan    = s2_q.longest;
    out_d.makespan_spread  = s2_q.spread;
    out_d.schedule_done    = s2_q.end_sched;

    pen_sum_d = s2_q.end_sched ? '0 : pen_sat;
    tard_d    = s2_q.end_sched ? '0 : tard_sat;
    late_d    = s2_q.end_sched ? '0 : late_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_sum_q <= '0;
      tard_q    <= '0;
      late_q    <= '0;
    end else if (fire3) begin
      pen_sum_q <= pen_sum_d;
      tard_q    <= tard_d;
      late_q    <= late_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire3) out_q <= out_d;
  end

  assign out_word_o = out_q;

  // Checks
  a_sched_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire3 && s2_q.end_sched |=> pen_sum_q == '0 && tard_q == '0 && late_q == '0)
    else $error("totals not cleared after end of schedule");

  a_machine_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire1 && end_m |=> at_start_q && mclk_q == '0 && prev_type_q == '0)
    else $error("machine state not restarted after last job");

  a_spread_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.makespan_spread <= out_word_o.peak_makespan)
    else $error("makespan spread exceeds maximum makespan");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> v0_q && v1_q && v2_q && out_v_q)
    else $error("input stalled with room in the pipeline");

endmodule

### tb/sv/ste_totals_checker.sv
`timescale 1ns / 1ps

// Watches both word channels and the set-up write port, predicts the running
// totals for every accepted job word and compares them with the result words.
module ste_totals_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  ste_pkg::in_word_t  in_word_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  ste_pkg::out_word_t out_word_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o
);

  localparam longint PenHi = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint PenLo = -PenHi - 1;

  // set-up times as last written
  logic [ste_pkg::SetupW-1:0] large_setup;
  logic [ste_pkg::SetupW-1:0] small_setup;

  // running state of the schedule being evaluated
  logic [ste_pkg::ClockW-1:0] mach_clock;
  logic [ste_pkg::TypeW-1:0]  prev_type;
  logic                       fresh_machine;
  longint                     pen_total;
  logic [63:0]                tard_total;
  logic [ste_pkg::CountW-1:0] late_total;
  logic [ste_pkg::CountW-1:0] setup_total;
  logic [ste_pkg::ClockW-1:0] longest;
  logic [ste_pkg::ClockW-1:0] shortest;

  ste_pkg::out_word_t expected_totals[$];

  function automatic void clear_totals();
    mach_clock    = '0;
    prev_type     = '0;
    fresh_machine = 1'b1;
    pen_total     = 0;
    tard_total    = '0;
    late_total    = '0;
    setup_total   = '0;
    longest       = '0;
    shortest      = ste_pkg::ClockMax;
  endfunction

  function automatic logic [ste_pkg::CountW-1:0] bump(input logic [ste_pkg::CountW-1:0] c);
    return (c == ste_pkg::CountMax) ? c : c + 1'b1;
  endfunction

  // totals after one job; updates the running state
  function automatic ste_pkg::out_word_t evaluate_job(input ste_pkg::in_word_t job);
    logic [ste_pkg::ClockW+2:0] finish;
    longint                     lateness;
    longint                     penalty;
    ste_pkg::out_word_t         r;
    if (fresh_machine) begin
      finish      = '0;
      setup_total = bump(setup_total);
    end else if (job.job_type != prev_type) begin
      finish      = {3'b000, mach_clock} + {15'd0, large_setup};
      setup_total = bump(setup_total);
    end else begin
      finish = {3'b000, mach_clock} + {15'd0, small_setup};
    end
    finish = finish + {15'd0, job.duration};
    if (finish > {3'b000, ste_pkg::ClockMax}) finish = {3'b000, ste_pkg::ClockMax};
    mach_clock    = finish[ste_pkg::ClockW-1:0];
    prev_type     = job.job_type;
    fresh_machine = 1'b0;

    // lateness in whole units, penalty in hundredths
    lateness  = longint'(mach_clock) - longint'(job.due_time);
    penalty   = (lateness >= 0) ? lateness * 100 : lateness;
    pen_total = pen_total + penalty;
    if (pen_total > PenHi) pen_total = PenHi;
    if (pen_total < PenLo) pen_total = PenLo;
    if (lateness > 0) begin
      tard_total = tard_total + 64'(lateness);
      if (tard_total > {24'd0, ste_pkg::TardMax}) tard_total = {24'd0, ste_pkg::TardMax};
      late_total = bump(late_total);
    end

    // machine closes, also on end of schedule
    if (job.last_of_machine || job.last_of_schedule) begin
      if (mach_clock > longest) longest = mach_clock;
      if (mach_clock < shortest) shortest = mach_clock;
      mach_clock    = '0;
      prev_type     = '0;
      fresh_machine = 1'b1;
    end

    r.scaled_tardiness = pen_total[ste_pkg::PenW-1:0];
    r.true_tardiness   = tard_total[ste_pkg::TardW-1:0];
    r.late_jobs        = late_total;
    r.large_setups     = setup_total;
    r.peak_makespan    = longest;
    r.makespan_spread  = (shortest <= longest) ? longest - shortest : '0;
    r.schedule_done    = job.last_of_schedule;
    if (job.last_of_schedule) clear_totals();
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] seen,
                                 input logic [63:0] want);
    if (fail_count_o < 30)
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, seen, want);
    fail_count_o++;
  endtask

  task automatic check_result(input ste_pkg::out_word_t got);
    ste_pkg::out_word_t want;
    if (expected_totals.size() == 0) begin
      report_mismatch("result word with nothing outstanding",
                      64'(got.scaled_tardiness), 64'd0);
      return;
    end
    want = expected_totals.pop_front();
    checked_o++;
    if (got.scaled_tardiness !== want.scaled_tardiness)
      report_mismatch("scaled_tardiness", 64'(got.scaled_tardiness),
                      64'(want.scaled_tardiness));
    if (got.true_tardiness !== want.true_tardiness)
      report_mismatch("true_tardiness", 64'(got.true_tardiness), 64'(want.true_tardiness));
    if (got.late_jobs !== want.late_jobs)
      report_mismatch("late_jobs", 64'(got.late_jobs), 64'(want.late_jobs));
    if (got.large_setups !== want.large_setups)
      report_mismatch("large_setups", 64'(got.large_setups), 64'(want.large_setups));
    if (got.peak_makespan !== want.peak_makespan)
      report_mismatch("peak_makespan", 64'(got.peak_makespan), 64'(want.peak_makespan));
    if (got.makespan_spread !== want.makespan_spread)
      report_mismatch("makespan_spread", 64'(got.makespan_spread),
                      64'(want.makespan_spread));
    if (got.schedule_done !== want.schedule_done)
      report_mismatch("schedule_done", 64'(got.schedule_done), 64'(want.schedule_done));
  endtask

  // results are compared before new jobs are predicted at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_totals();
      large_setup = '0;
      small_setup = '0;
      expected_totals.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_result(out_word_i);
      if (in_valid_i && !in_stall_i)
        expected_totals.insert(expected_totals.size(), evaluate_job(in_word_i));
      if (cfg_we_i) begin
        if (cfg_index_i == ste_pkg::CFG_LARGE_SETUP) large_setup = cfg_data_i;
        else if (cfg_index_i == ste_pkg::CFG_SMALL_SETUP) small_setup = cfg_data_i;
      end
    end
    pending_o = expected_totals.size();
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int CycleLimit = 600000;
  localparam int LongJobs   = 500;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [0:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  ste_pkg::in_word_t  in_word;
  logic               out_valid;
  logic               out_stall;
  ste_pkg::out_word_t out_word;

  int fail_count;
  int pending;
  int checked;
  int jobs_sent;
  int schedules;
  int cycles;
  bit steady;

  schedule_tardiness_evaluator_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  ste_totals_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_word_i   (out_word),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // guard against a hung pipeline
  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // result side stalls now and then
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_stall = !steady && ($urandom_range(99) < 6);
    end
  end

  function automatic ste_pkg::in_word_t job(input logic [7:0] ty, input logic [23:0] due,
                                            input logic [15:0] dur, input logic lom,
                                            input logic los);
    ste_pkg::in_word_t w;
    w.job_type         = ty;
    w.due_time         = due;
    w.duration         = dur;
    w.last_of_machine  = lom;
    w.last_of_schedule = los;
    return w;
  endfunction

  // offer one word from a falling edge; return at the falling edge after it is taken
  task automatic send_job(input ste_pkg::in_word_t w);
    if (!steady && $urandom_range(99) < 3) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_word  = w;
    do @(posedge clk); while (in_stall);
    jobs_sent++;
    if (w.last_of_schedule) schedules++;
    @(negedge clk);
  endtask

  // drain the pipeline before a set-up write or the end
  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_setups(input logic [15:0] large_t, input logic [15:0] small_t);
    cfg_we    = 1'b1;
    cfg_index = ste_pkg::CFG_LARGE_SETUP;
    cfg_data  = large_t;
    @(negedge clk);
    cfg_index = ste_pkg::CFG_SMALL_SETUP;
    cfg_data  = small_t;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // whole random schedules, with a sprinkling of arbitrary words
  task automatic run_schedules(input int quota, input int unsigned setup_guess);
    int                sent;
    int                machines;
    int                jobs;
    int unsigned       clock_guess;
    ste_pkg::in_word_t w;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(9) == 0) begin
        w.job_type         = 8'($urandom_range(0, 255));
        w.due_time         = 24'($urandom_range(0, 24'hFFFFFF));
        w.duration         = 16'($urandom_range(0, 16'hFFFF));
        w.last_of_machine  = 1'($urandom_range(0, 1));
        w.last_of_schedule = ($urandom_range(7) == 0);
        send_job(w);
        sent++;
      end else begin
        machines = $urandom_range(1, 5);
        for (int m = 0; m < machines; m++) begin
          jobs = $urandom_range(1, 8);
          clock_guess = 0;
          for (int j = 0; j < jobs; j++) begin
            w.job_type = ($urandom_range(3) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, 3));
            w.duration = ($urandom_range(3) == 0) ? 16'($urandom_range(0, 16'hFFFF))
                                                  : 16'($urandom_range(0, 3000));
            clock_guess = clock_guess + {16'd0, w.duration} + setup_guess;
            if ($urandom_range(4) == 0) w.due_time = 24'($urandom_range(0, 24'hFFFFFF));
            else if (clock_guess > 24'h7FFFFF)
              w.due_time = 24'($urandom_range(0, 24'hFFFFFF));
            else w.due_time = 24'($urandom_range(0, 2 * clock_guess + 100));
            w.last_of_machine  = (j == jobs - 1);
            w.last_of_schedule = (j == jobs - 1) && (m == machines - 1);
            send_job(w);
            sent++;
          end
        end
      end
    end
  endtask

  initial begin
    logic [15:0] lg;
    logic [15:0] sm;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = ste_pkg::CFG_LARGE_SETUP;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_word   = '0;
    steady    = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // set-up times still at reset: trivial schedule, then early/late and closes
    send_job(job(8'd0, 24'd0, 16'd0, 1'b1, 1'b1));
    send_job(job(8'd255, 24'hFFFFFF, 16'hFFFF, 1'b0, 1'b0));
    send_job(job(8'd255, 24'd0, 16'hFFFF, 1'b0, 1'b0));
    send_job(job(8'd7, 24'd100, 16'd1, 1'b1, 1'b0));
    send_job(job(8'd0, 24'd0, 16'd0, 1'b0, 1'b1));
    settle();

    // full-scale change-over, no same-type set-up
    write_setups(16'hFFFF, 16'h0000);
    send_job(job(8'd1, 24'd50, 16'd10, 1'b0, 1'b0));
    send_job(job(8'd2, 24'd0, 16'd0, 1'b0, 1'b0));
    send_job(job(8'd2, 24'hFFFFFF, 16'hFFFF, 1'b0, 1'b0));
    send_job(job(8'd2, 24'd131080, 16'd5, 1'b1, 1'b0));
    send_job(job(8'd9, 24'd0, 16'hFFFF, 1'b0, 1'b0));
    send_job(job(8'd9, 24'd0, 16'hFFFF, 1'b1, 1'b1));
    settle();

    // and the other way round
    write_setups(16'h0000, 16'hFFFF);
    send_job(job(8'd128, 24'd65535, 16'hFFFF, 1'b0, 1'b0));
    send_job(job(8'd128, 24'd0, 16'hFFFF, 1'b0, 1'b0));
    send_job(job(8'd127, 24'hFFFFFF, 16'd0, 1'b0, 1'b0));
    send_job(job(8'd127, 24'd1, 16'd1, 1'b1, 1'b0));
    send_job(job(8'd200, 24'd3, 16'd2, 1'b1, 1'b1));
    settle();

    // one long machine with full-scale set-ups and durations: large sums
    write_setups(16'hFFFF, 16'hFFFF);
    for (int i = 0; i < LongJobs; i++) begin
      send_job(job((i % 7 == 3) ? 8'hA5 : ((i % 2) ? 8'hA5 : 8'h5A),
                   24'($urandom_range(0, 1000)), 16'hFFFF, 1'b0, (i == LongJobs - 1)));
    end
    settle();

    // random schedules under several set-up settings
    for (int s = 0; s < 4; s++) begin
      case (s)
        0: begin
          lg = 16'($urandom_range(0, 16'hFFFF));
          sm = 16'($urandom_range(0, 16'hFFFF));
        end
        1: begin
          lg = 16'($urandom_range(0, 200));
          sm = 16'($urandom_range(0, 200));
        end
        2: begin
          lg = '0;
          sm = '0;
        end
        default: begin
          lg = 16'($urandom_range(0, 16'hFFFF));
          sm = 16'($urandom_range(0, 16'hFFFF));
        end
      endcase
      write_setups(lg, sm);
      steady = (s == 1);
      run_schedules(270, {16'd0, lg});
      steady = 1'b0;
      settle();
    end

    $display("%0d job words in %0d schedules sent, %0d result words checked",
             jobs_sent, schedules, checked);
    $display("set-up times at zero, full scale and random; one long full-scale machine");
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
